// ----- hw/rtl/evc_pkg.sv -----
// Package for the enclosed voxel cull block: field widths, item types,
// mode and face codes. No dependencies.
package evc_pkg;

   // Field widths of the request and response items
   localparam int MODE_W  = 2;
   localparam int FACE_W  = 3;
   localparam int POS_W   = 4;
   localparam int VALUE_W = 16;

   typedef logic [MODE_W-1:0]  mode_type;
   typedef logic [FACE_W-1:0]  face_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [VALUE_W-1:0] value_type;

   // Request modes; the fourth code is ignored
   localparam mode_type MODE_WR_VOXEL = 2'd0;
   localparam mode_type MODE_WR_FLAG  = 2'd1;
   localparam mode_type MODE_QUERY    = 2'd2;

   // Faces of the chunk; codes above FACE_NZ are ignored
   localparam face_type FACE_PX = 3'd0;
   localparam face_type FACE_PY = 3'd1;
   localparam face_type FACE_PZ = 3'd2;
   localparam face_type FACE_NX = 3'd3;
   localparam face_type FACE_NY = 3'd4;
   localparam face_type FACE_NZ = 3'd5;

endpackage

// ----- hw/rtl/evc_req_if.sv -----
// Request channel of the enclosed voxel cull block: valid/ready plus item fields.
// Depends on evc_pkg.
interface evc_req_if;
   logic                valid;
   logic                ready;
   evc_pkg::mode_type   mode;
   evc_pkg::face_type   face;
   evc_pkg::pos_type    pos_x;
   evc_pkg::pos_type    pos_y;
   evc_pkg::pos_type    pos_z;
   evc_pkg::value_type  value;

   modport source (output valid, mode, face, pos_x, pos_y, pos_z, value, input ready);
   modport sink   (input valid, mode, face, pos_x, pos_y, pos_z, value, output ready);
endinterface

// ----- hw/rtl/evc_rsp_if.sv -----
// Response channel of the enclosed voxel cull block: valid/ready plus result fields.
// Depends on evc_pkg.
interface evc_rsp_if;
   logic                valid;
   logic                ready;
   evc_pkg::value_type  cleaned_value;
   logic                was_hidden;

   modport source (output valid, cleaned_value, was_hidden, input ready);
   modport sink   (input valid, cleaned_value, was_hidden, output ready);
endinterface

// ----- hw/rtl/evc_ram.sv -----
// Single-port synchronous RAM with a registered read, used for the voxel
// store and the face flag planes. No dependencies.
module evc_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One access a cycle: a write, or else a registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/enclosed_voxel_cull.sv -----
// Enclosed voxel cull: a cubic chunk of block indices with six face flag planes,
// answering per-voxel queries with hidden voxels culled to zero.
// Depends on evc_pkg, evc_req_if, evc_rsp_if and evc_ram.
//
// Usage:
//   req_ch carries one item per valid/ready handshake. Mode 0 writes a voxel,
//   mode 1 writes one face flag (value nonzero), mode 2 queries a voxel. Writes
//   give no result; a query gives exactly one item on rsp_ch.
//   Writes are taken back to back while idle. A query reads the centre voxel and
//   its six neighbours one after another through the single port of the voxel
//   store (a neighbour past the chunk edge is read from the flag store instead),
//   so a query holds the block busy: the result is loaded into the response
//   register once the last neighbour is evaluated, and req_ch.ready returns then.
//   A query with a coordinate outside the chunk answers zero and reads no store.
//   If rsp_ch stalls, the result waits in its register and writes are still
//   accepted; a second query then waits for the slot before finishing.
//   Reset clears the sequencer and the response valid; the stores keep their
//   contents and are undefined until written. There is no clearing pass.
module enclosed_voxel_cull #(
   parameter int CHUNK_SIZE  = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   evc_req_if.sink  req_ch,
   evc_rsp_if.source rsp_ch
);

   localparam int CW       = $clog2(CHUNK_SIZE);
   localparam int VOX_N    = CHUNK_SIZE * CHUNK_SIZE * CHUNK_SIZE;
   localparam int FLAG_N   = 6 * CHUNK_SIZE * CHUNK_SIZE;
   localparam int VA       = $clog2(VOX_N);
   localparam int FA       = $clog2(FLAG_N);
   localparam int VW       = VALUE_WIDTH;

   // Read sequence of a query: centre, then the six neighbours
   localparam logic [2:0] STEP_CENTRE = 3'd0;
   localparam logic [2:0] STEP_PX     = 3'd1;
   localparam logic [2:0] STEP_PY     = 3'd2;
   localparam logic [2:0] STEP_PZ     = 3'd3;
   localparam logic [2:0] STEP_NX     = 3'd4;
   localparam logic [2:0] STEP_NY     = 3'd5;
   localparam logic [2:0] STEP_NZ     = 3'd6;
   localparam logic [2:0] STEP_END    = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef logic [CW-1:0] coord_type;

   function automatic logic [VA-1:0] vox_addr(coord_type x, coord_type y, coord_type z);
      return VA'(x) * VA'(CHUNK_SIZE * CHUNK_SIZE) + VA'(y) * VA'(CHUNK_SIZE) + VA'(z);
   endfunction

   function automatic logic [FA-1:0] flag_addr(evc_pkg::face_type f, coord_type a,
                                               coord_type b);
      return FA'(f) * FA'(CHUNK_SIZE * CHUNK_SIZE) + FA'(a) * FA'(CHUNK_SIZE) + FA'(b);
   endfunction

   state_type         state_ff, state_in;
   coord_type         x_ff, y_ff, z_ff;
   logic [VA-1:0]     base_ff;
   logic [2:0]        step_ff, step_in;
   logic              issue_ff;
   logic [2:0]        eval_step_ff;
   logic              src_flag_ff;
   logic [VW-1:0]     centre_ff;
   logic              enc_ff;
   evc_pkg::value_type res_val_ff, res_val_in;
   logic              res_hid_ff, res_hid_in;
   logic              rsp_valid_ff;
   evc_pkg::value_type rsp_val_ff;
   logic              rsp_hid_ff;

   // Memory ports
   logic              vox_wr, vox_rd, flag_wr, flag_rd;
   logic [VA-1:0]     vox_a, vox_rd_a;
   logic [FA-1:0]     flag_a, flag_rd_a;
   logic [VW-1:0]     vox_q;
   logic [0:0]        flag_q;

   logic              accept, slot_free, finish;
   logic              in_range;
   coord_type         in_x, in_y, in_z, in_a, in_b;
   logic              ab_range, face_ok;
   logic              issuing, at_rim, nb_set, enc_all;

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // Decode of the request coordinates
   assign in_x = CW'(req_ch.pos_x);
   assign in_y = CW'(req_ch.pos_y);
   assign in_z = CW'(req_ch.pos_z);
   assign in_range = (32'(req_ch.pos_x) < CHUNK_SIZE) && (32'(req_ch.pos_y) < CHUNK_SIZE)
                     && (32'(req_ch.pos_z) < CHUNK_SIZE);

   // Face write: pick the two in-plane coordinates
   always_comb begin
      face_ok  = 1'b1;
      in_a     = in_y;
      in_b     = in_z;
      ab_range = (32'(req_ch.pos_y) < CHUNK_SIZE) && (32'(req_ch.pos_z) < CHUNK_SIZE);
      case (req_ch.face)
         evc_pkg::FACE_PX, evc_pkg::FACE_NX: begin
            in_a     = in_y;
            in_b     = in_z;
            ab_range = (32'(req_ch.pos_y) < CHUNK_SIZE) && (32'(req_ch.pos_z) < CHUNK_SIZE);
         end
         evc_pkg::FACE_PY, evc_pkg::FACE_NY: begin
            in_a     = in_x;
            in_b     = in_z;
            ab_range = (32'(req_ch.pos_x) < CHUNK_SIZE) && (32'(req_ch.pos_z) < CHUNK_SIZE);
         end
         evc_pkg::FACE_PZ, evc_pkg::FACE_NZ: begin
            in_a     = in_x;
            in_b     = in_y;
            ab_range = (32'(req_ch.pos_x) < CHUNK_SIZE) && (32'(req_ch.pos_y) < CHUNK_SIZE);
         end
         default: begin
            face_ok = 1'b0;
         end
      endcase
   end

   // Read address for the current step of a query
   assign issuing = (state_ff == ST_RUN) && (step_ff != STEP_END);

   always_comb begin
      at_rim    = 1'b0;
      vox_rd_a  = base_ff;
      flag_rd_a = flag_addr(evc_pkg::FACE_PX, y_ff, z_ff);
      case (step_ff)
         STEP_PX: begin
            at_rim    = (x_ff == CW'(CHUNK_SIZE - 1));
            vox_rd_a  = base_ff + VA'(CHUNK_SIZE * CHUNK_SIZE);
            flag_rd_a = flag_addr(evc_pkg::FACE_PX, y_ff, z_ff);
         end
         STEP_PY: begin
            at_rim    = (y_ff == CW'(CHUNK_SIZE - 1));
            vox_rd_a  = base_ff + VA'(CHUNK_SIZE);
            flag_rd_a = flag_addr(evc_pkg::FACE_PY, x_ff, z_ff);
         end
         STEP_PZ: begin
            at_rim    = (z_ff == CW'(CHUNK_SIZE - 1));
            vox_rd_a  = base_ff + VA'(1);
            flag_rd_a = flag_addr(evc_pkg::FACE_PZ, x_ff, y_ff);
         end
         STEP_NX: begin
            at_rim    = (x_ff == '0);
            vox_rd_a  = base_ff - VA'(CHUNK_SIZE * CHUNK_SIZE);
            flag_rd_a = flag_addr(evc_pkg::FACE_NX, y_ff, z_ff);
         end
         STEP_NY: begin
            at_rim    = (y_ff == '0);
            vox_rd_a  = base_ff - VA'(CHUNK_SIZE);
            flag_rd_a = flag_addr(evc_pkg::FACE_NY, x_ff, z_ff);
         end
         STEP_NZ: begin
            at_rim    = (z_ff == '0);
            vox_rd_a  = base_ff - VA'(1);
            flag_rd_a = flag_addr(evc_pkg::FACE_NZ, x_ff, y_ff);
         end
         default: begin
            at_rim = 1'b0;
         end
      endcase
   end

   // Port selection: writes only in idle, reads only while running
   assign vox_wr  = accept && (req_ch.mode == evc_pkg::MODE_WR_VOXEL) && in_range;
   assign flag_wr = accept && (req_ch.mode == evc_pkg::MODE_WR_FLAG) && face_ok && ab_range;
   assign vox_rd  = issuing && !at_rim;
   assign flag_rd = issuing && at_rim;
   assign vox_a   = (state_ff == ST_IDLE) ? vox_addr(in_x, in_y, in_z) : vox_rd_a;
   assign flag_a  = (state_ff == ST_IDLE) ? flag_addr(req_ch.face, in_a, in_b) : flag_rd_a;

   evc_ram #(.DEPTH(VOX_N), .WIDTH(VW)) u_vox_ram (
      .clock   (clock),
      .wr_en   (vox_wr),
      .rd_en   (vox_rd),
      .addr    (vox_a),
      .wr_data (VW'(req_ch.value)),
      .rd_data (vox_q)
   );

   evc_ram #(.DEPTH(FLAG_N), .WIDTH(1)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_wr),
      .rd_en   (flag_rd),
      .addr    (flag_a),
      .wr_data (req_ch.value != '0),
      .rd_data (flag_q)
   );

   // Evaluation of the data read in the previous cycle
   assign nb_set  = src_flag_ff ? flag_q[0] : (vox_q != '0);
   assign enc_all = enc_ff && nb_set;

   // Sequencer and result selection
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      finish     = 1'b0;
      res_val_in = res_val_ff;
      res_hid_in = res_hid_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = STEP_CENTRE;
            if (accept && (req_ch.mode == evc_pkg::MODE_QUERY)) begin
               if (in_range) begin
                  state_in = ST_RUN;
               end else begin
                  res_val_in = '0;
                  res_hid_in = 1'b0;
                  finish     = 1'b1;
               end
            end
         end
         ST_RUN: begin
            if (issuing) begin
               step_in = step_ff + 3'd1;
            end
            if (issue_ff && (eval_step_ff == STEP_NZ)) begin
               res_hid_in = (centre_ff != '0) && enc_all;
               res_val_in = res_hid_in ? '0 : evc_pkg::VALUE_W'(centre_ff);
               finish     = 1'b1;
            end
         end
         ST_DONE: begin
            finish = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         state_in = slot_free ? ST_IDLE : ST_DONE;
      end
   end

   // State, datapath and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_CENTRE;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         issue_ff     <= issuing;
         eval_step_ff <= step_ff;
         src_flag_ff  <= at_rim;
         res_val_ff   <= res_val_in;
         res_hid_ff   <= res_hid_in;

         // Latch the query position
         if (accept) begin
            x_ff    <= in_x;
            y_ff    <= in_y;
            z_ff    <= in_z;
            base_ff <= vox_addr(in_x, in_y, in_z);
            enc_ff  <= 1'b1;
         end

         // Collect centre and neighbour results
         if (issue_ff) begin
            if (eval_step_ff == STEP_CENTRE) begin
               centre_ff <= vox_q;
            end else begin
               enc_ff <= enc_all;
            end
         end

         // Response register
         if (finish && slot_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_val_ff   <= res_val_in;
            rsp_hid_ff   <= res_hid_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.cleaned_value = rsp_val_ff;
   assign rsp_ch.was_hidden    = rsp_hid_ff;

endmodule

// ----- dv/evc_cull_checker.sv -----
// Checker for the enclosed voxel cull block: watches both channels, keeps its own
// copy of the chunk and the face flag planes, predicts each query and compares.
// Depends on evc_pkg, evc_req_if and evc_rsp_if.
module evc_cull_checker (
   input  logic clock,
   input  logic reset,
   evc_req_if   req_ch,
   evc_rsp_if   rsp_ch,
   output int   fail_count,
   output int   results_outstanding,
   output int   queries_seen,
   output int   hidden_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHUNK = 16;
   localparam int LAST  = CHUNK - 1;
   localparam int PLANE = CHUNK * CHUNK;

   typedef struct packed {
      evc_pkg::value_type cleaned_value;
      logic               was_hidden;
   } cull_result_type;

   // Shadow stores; left unknown until written, like the block's own
   evc_pkg::value_type voxel_mem [CHUNK*PLANE];
   logic               flag_mem  [6*PLANE];
   cull_result_type    pending_culls [$];

   int n_fail    = 0;
   int n_queries = 0;
   int n_hidden  = 0;
   int n_left    = 0;

   assign fail_count          = n_fail;
   assign results_outstanding = n_left;
   assign queries_seen        = n_queries;
   assign hidden_seen         = n_hidden;

   function automatic int voxel_addr(input int x, y, z);
      return (x * CHUNK + y) * CHUNK + z;
   endfunction

   // Cell of a face plane: x faces use (y,z), y faces (x,z), z faces (x,y)
   function automatic int flag_cell(input int face, x, y, z);
      case (face % 3)
         0:       return face * PLANE + y * CHUNK + z;
         1:       return face * PLANE + x * CHUNK + z;
         default: return face * PLANE + x * CHUNK + y;
      endcase
   endfunction

   function automatic logic filled(input int x, y, z);
      return voxel_mem[voxel_addr(x, y, z)] != '0;
   endfunction

   // Expected answer to a query; 4-bit coordinates always lie inside the chunk
   function automatic cull_result_type cull_query(input int x, y, z);
      cull_result_type res;
      logic            enclosed;
      res.cleaned_value = voxel_mem[voxel_addr(x, y, z)];
      res.was_hidden    = 1'b0;
      if (res.cleaned_value != '0) begin
         enclosed = ((x < LAST) ? filled(x + 1, y, z)
                                : flag_mem[flag_cell(evc_pkg::FACE_PX, x, y, z)])
                 && ((y < LAST) ? filled(x, y + 1, z)
                                : flag_mem[flag_cell(evc_pkg::FACE_PY, x, y, z)])
                 && ((z < LAST) ? filled(x, y, z + 1)
                                : flag_mem[flag_cell(evc_pkg::FACE_PZ, x, y, z)])
                 && ((x > 0)    ? filled(x - 1, y, z)
                                : flag_mem[flag_cell(evc_pkg::FACE_NX, x, y, z)])
                 && ((y > 0)    ? filled(x, y - 1, z)
                                : flag_mem[flag_cell(evc_pkg::FACE_NY, x, y, z)])
                 && ((z > 0)    ? filled(x, y, z - 1)
                                : flag_mem[flag_cell(evc_pkg::FACE_NZ, x, y, z)]);
         if (enclosed) begin
            res.cleaned_value = '0;
            res.was_hidden    = 1'b1;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cull_result_type want;
      if (!reset) begin
         // result side: oldest expectation first
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_culls.size() == 0) begin
               $error("unexpected result item: cleaned_value %0h was_hidden %0b",
                      rsp_ch.cleaned_value, rsp_ch.was_hidden);
               n_fail++;
            end else begin
               want = pending_culls.pop_front();
               if (rsp_ch.cleaned_value !== want.cleaned_value) begin
                  $error("cleaned_value: expected %0h, actual %0h",
                         want.cleaned_value, rsp_ch.cleaned_value);
                  n_fail++;
               end
               if (rsp_ch.was_hidden !== want.was_hidden) begin
                  $error("was_hidden: expected %0b, actual %0b",
                         want.was_hidden, rsp_ch.was_hidden);
                  n_fail++;
               end
               if (want.was_hidden) n_hidden++;
            end
         end
         // request side: update the shadow stores or queue a prediction
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.mode)
               evc_pkg::MODE_WR_VOXEL: begin
                  voxel_mem[voxel_addr(req_ch.pos_x, req_ch.pos_y, req_ch.pos_z)] =
                     req_ch.value;
               end
               evc_pkg::MODE_WR_FLAG: begin
                  if (req_ch.face <= evc_pkg::FACE_NZ)
                     flag_mem[flag_cell(req_ch.face, req_ch.pos_x, req_ch.pos_y,
                                        req_ch.pos_z)] = (req_ch.value != '0);
               end
               evc_pkg::MODE_QUERY: begin
                  pending_culls.push_back(cull_query(req_ch.pos_x, req_ch.pos_y,
                                                     req_ch.pos_z));
                  n_queries++;
               end
               default: ;
            endcase
         end
      end
      n_left = pending_culls.size();
   end

endmodule

// ----- dv/tb_enclosed_voxel_cull.sv -----
// Testbench top for the enclosed voxel cull block: clock, reset, item stimulus with
// idling phases, and the verdict. Depends on evc_pkg, the channel interfaces,
// enclosed_voxel_cull and evc_cull_checker.
module tb_enclosed_voxel_cull;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS  = 1550;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 20;
   localparam int CHUNK         = 16;
   localparam int LAST          = CHUNK - 1;
   localparam int PLANE         = CHUNK * CHUNK;
   localparam int CENTRE        = 6;   // cell index of the queried voxel itself

   localparam evc_pkg::mode_type MODE_UNUSED   = 2'd3;
   localparam evc_pkg::face_type FACE_SPARE_LO = 3'd6;
   localparam evc_pkg::face_type FACE_SPARE_HI = 3'd7;

   // Offsets of the six neighbours in face order, then the centre
   localparam int DX [0:6] = '{1, 0, 0, -1, 0, 0, 0};
   localparam int DY [0:6] = '{0, 1, 0, 0, -1, 0, 0};
   localparam int DZ [0:6] = '{0, 0, 1, 0, 0, -1, 0};

   logic clock = 1'b0;
   logic reset;

   int idle_pct    = 0;
   int stall_pct   = 0;
   int work_items  = 0;
   int cycle_count = 0;

   // Which cells have been written, so no query reads an unwritten one
   bit voxel_written [CHUNK*PLANE];
   bit flag_written  [6*PLANE];

   int fail_count;
   int results_outstanding;
   int queries_seen;
   int hidden_seen;

   evc_req_if req_ch ();
   evc_rsp_if rsp_ch ();

   enclosed_voxel_cull #(
      .CHUNK_SIZE  (CHUNK),
      .VALUE_WIDTH (16)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   evc_cull_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_ch              (req_ch),
      .rsp_ch              (rsp_ch),
      .fail_count          (fail_count),
      .results_outstanding (results_outstanding),
      .queries_seen        (queries_seen),
      .hidden_seen         (hidden_seen)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic evc_pkg::value_type random_value();
      case ($urandom_range(0, 9))
         0, 1:    return '0;
         2:       return '1;
         3:       return evc_pkg::value_type'(1) << $urandom_range(0, 15);
         default: return evc_pkg::value_type'($urandom);
      endcase
   endfunction

   // Bias towards the chunk edges and a small corner region so cells get reused
   function automatic int pick_coord();
      case ($urandom_range(0, 9))
         0, 1:    return 0;
         2, 3:    return LAST;
         4, 5, 6: return $urandom_range(0, 3);
         default: return $urandom_range(0, LAST);
      endcase
   endfunction

   function automatic int flag_slot(input int face, x, y, z);
      case (face % 3)
         0:       return face * PLANE + y * CHUNK + z;
         1:       return face * PLANE + x * CHUNK + z;
         default: return face * PLANE + x * CHUNK + y;
      endcase
   endfunction

   // Where neighbour dir of voxel (x,y,z) lives: a voxel, or a face flag past the edge
   function automatic void locate_cell(input int dir, x, y, z,
                                       output bit is_flag, output int idx);
      int nx, ny, nz;
      nx = x + DX[dir];
      ny = y + DY[dir];
      nz = z + DZ[dir];
      is_flag = (nx < 0 || nx > LAST || ny < 0 || ny > LAST || nz < 0 || nz > LAST);
      idx = is_flag ? flag_slot(dir, x, y, z) : (nx * CHUNK + ny) * CHUNK + nz;
   endfunction

   function automatic bit neighbourhood_written(input int x, y, z);
      bit is_flag;
      int idx;
      for (int d = 0; d <= CENTRE; d++) begin
         locate_cell(d, x, y, z, is_flag, idx);
         if (is_flag ? !flag_written[idx] : !voxel_written[idx]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // One item on the request channel; called and returns at a falling edge
   task automatic send_item(input evc_pkg::mode_type mode, input evc_pkg::face_type face,
                            input int x, y, z, input evc_pkg::value_type value);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= mode;
      req_ch.face  <= face;
      req_ch.pos_x <= evc_pkg::pos_type'(x);
      req_ch.pos_y <= evc_pkg::pos_type'(y);
      req_ch.pos_z <= evc_pkg::pos_type'(z);
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (!(mode == MODE_UNUSED || (mode == evc_pkg::MODE_WR_FLAG && face > evc_pkg::FACE_NZ)))
         work_items++;
   endtask

   task automatic send_query(input int x, y, z);
      send_item(evc_pkg::MODE_QUERY, evc_pkg::face_type'($urandom_range(0, 7)), x, y, z,
                random_value());
   endtask

   // Write neighbour dir (or the centre) of voxel (x,y,z)
   task automatic write_cell(input int dir, x, y, z, input evc_pkg::value_type value);
      bit is_flag;
      int idx;
      int fx, fy, fz;
      locate_cell(dir, x, y, z, is_flag, idx);
      if (is_flag) begin
         fx = x;
         fy = y;
         fz = z;
         // coordinate along the face normal is don't-care: scramble it
         case (dir % 3)
            0:       fx = $urandom_range(0, LAST);
            1:       fy = $urandom_range(0, LAST);
            default: fz = $urandom_range(0, LAST);
         endcase
         send_item(evc_pkg::MODE_WR_FLAG, evc_pkg::face_type'(dir), fx, fy, fz, value);
         flag_written[idx] = 1'b1;
      end else begin
         send_item(evc_pkg::MODE_WR_VOXEL, evc_pkg::face_type'($urandom_range(0, 7)),
                   x + DX[dir], y + DY[dir], z + DZ[dir], value);
         voxel_written[idx] = 1'b1;
      end
   endtask

   // Hold the sender until every query has been answered
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (results_outstanding != 0);
   endtask

   task automatic run_directed();
      // origin corner: the three low neighbours come from the flag planes
      write_cell(CENTRE, 0, 0, 0, 16'hFFFF);
      for (int d = 0; d < CENTRE; d++)
         write_cell(d, 0, 0, 0, evc_pkg::value_type'(16'h0001 << (d * 3)));
      send_query(0, 0, 0);
      // one open face flag
      write_cell(evc_pkg::FACE_NZ, 0, 0, 0, '0);
      send_query(0, 0, 0);
      // flag closed again, inner neighbour emptied
      write_cell(evc_pkg::FACE_NZ, 0, 0, 0, 16'h5A5A);
      write_cell(evc_pkg::FACE_PX, 0, 0, 0, '0);
      send_query(0, 0, 0);
      // empty voxel
      write_cell(CENTRE, 0, 0, 0, '0);
      send_query(0, 0, 0);
      // far corner: the three high neighbours come from the flag planes
      for (int d = 0; d <= CENTRE; d++)
         write_cell(d, LAST, LAST, LAST, (d == CENTRE) ? 16'h0001 : 16'h8000);
      send_query(LAST, LAST, LAST);
      // items the block must ignore
      send_item(MODE_UNUSED, evc_pkg::FACE_PX, LAST, 0, LAST, '1);
      send_item(evc_pkg::MODE_WR_FLAG, FACE_SPARE_LO, 0, 0, 0, '1);
      send_item(evc_pkg::MODE_WR_FLAG, FACE_SPARE_HI, LAST, LAST, LAST, '1);
   endtask

   task automatic random_step();
      int cx, cy, cz;
      int rot, pick;
      bit is_flag;
      int idx;
      pick = $urandom_range(0, 99);
      cx = pick_coord();
      cy = pick_coord();
      cz = pick_coord();
      if (pick < 80) begin
         // complete neighbourhood, then a query; sometimes change one cell and ask again
         rot = $urandom_range(0, CENTRE);
         for (int k = 0; k <= CENTRE; k++) begin
            locate_cell((k + rot) % 7, cx, cy, cz, is_flag, idx);
            if ((is_flag ? !flag_written[idx] : !voxel_written[idx]) ||
                $urandom_range(0, 3) == 0)
               write_cell((k + rot) % 7, cx, cy, cz, random_value());
         end
         send_query(cx, cy, cz);
         if ($urandom_range(0, 3) == 0) begin
            write_cell($urandom_range(0, CENTRE), cx, cy, cz, random_value());
            send_query(cx, cy, cz);
         end
         if ($urandom_range(0, 99) == 0) wait_drained();
      end else if (pick < 86) begin
         // abandoned neighbourhood: writes with no query
         repeat ($urandom_range(1, 3))
            write_cell($urandom_range(0, CENTRE), cx, cy, cz, random_value());
      end else begin
         case ($urandom_range(0, 2))
            0: send_item(MODE_UNUSED, evc_pkg::face_type'($urandom_range(0, 7)), cx, cy, cz,
                         random_value());
            1: send_item(evc_pkg::MODE_WR_FLAG,
                         evc_pkg::face_type'($urandom_range(FACE_SPARE_LO, FACE_SPARE_HI)),
                         cx, cy, cz, random_value());
            default: begin
               if (neighbourhood_written(cx, cy, cz))
                  send_query(cx, cy, cz);
               else
                  write_cell($urandom_range(0, CENTRE), cx, cy, cz, random_value());
            end
         endcase
      end
   endtask

   initial begin
      int seq_start;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode  = evc_pkg::MODE_WR_VOXEL;
      req_ch.face  = evc_pkg::FACE_PX;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      req_ch.value = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      run_directed();
      wait_drained();

      // random part in four idling mixes, draining between them
      seq_start = work_items;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 57; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 9;  stall_pct = 9;  end
         endcase
         while (work_items < seq_start + RANDOM_ITEMS * (phase + 1) / 4)
            random_step();
         wait_drained();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Run covered %0d items with %0d queries, %0d of them culled as enclosed,",
               work_items, queries_seen, hidden_seen);
      $display("including both chunk corners, ignored modes and faces, and four idling mixes.");
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
